// File: rtl/core/gdsd_pkg.sv
`timescale 1ns / 1ps

package gdsd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 15;
    localparam int unsigned Q100_W  = 9;
    localparam int unsigned DNUM_W  = 24;
    localparam int unsigned DIFF_W  = 25;
    localparam int unsigned OFF_W   = 9;

    localparam logic [YEAR_W-1:0]  C_YEAR_MIN = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0]  C_YEAR_MAX = YEAR_W'(30000);
    localparam logic [MONTH_W-1:0] C_JAN      = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] C_FEB      = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] C_DEC      = MONTH_W'(12);

    // Raw dates plus the hundreds of the year and of the March-based year.
    typedef struct packed {
        logic [DAY_W-1:0]   d1;
        logic [MONTH_W-1:0] m1;
        logic [YEAR_W-1:0]  y1;
        logic [DAY_W-1:0]   d2;
        logic [MONTH_W-1:0] m2;
        logic [YEAR_W-1:0]  y2;
        logic [Q100_W-1:0]  q1;
        logic [Q100_W-1:0]  q2;
        logic [YEAR_W-1:0]  ya1;
        logic [YEAR_W-1:0]  ya2;
        logic [Q100_W-1:0]  qa1;
        logic [Q100_W-1:0]  qa2;
    } t_s1;

    typedef struct packed {
        logic               v1;
        logic               v2;
        logic [DAY_W-1:0]   d1;
        logic [MONTH_W-1:0] m1;
        logic [YEAR_W-1:0]  y1;
        logic [DAY_W-1:0]   len1;
        logic [DAY_W-1:0]   prev_len1;
        logic [DNUM_W-1:0]  n1;
        logic [DNUM_W-1:0]  n2;
    } t_s2;

    typedef struct packed {
        logic                     first_valid;
        logic                     second_valid;
        logic [DAY_W-1:0]         month_length;
        logic [DAY_W-1:0]         next_day;
        logic [MONTH_W-1:0]       next_month;
        logic [YEAR_W-1:0]        next_year;
        logic [DAY_W-1:0]         prev_day;
        logic [MONTH_W-1:0]       prev_month;
        logic [YEAR_W-1:0]        prev_year;
        logic signed [DIFF_W-1:0] day_difference;
    } t_res;

    // Exact floor(y / 100) for every 15-bit value, by reciprocal multiply.
    function automatic logic [Q100_W-1:0] f_div100(input logic [YEAR_W-1:0] y);
        logic [27:0] p;
        p = 28'(y) * 28'd5243;
        return p[27:19];
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            default:                                    len = leap ? DAY_W'(29)
                                                                   : DAY_W'(28);
        endcase
        return len;
    endfunction

    // Days from 1 March to the first of the month, the year starting in March.
    function automatic logic [OFF_W-1:0] f_month_offset(input logic [MONTH_W-1:0] m);
        logic [OFF_W-1:0] off;
        unique case (m)
            4'd3:    off = OFF_W'(0);
            4'd4:    off = OFF_W'(31);
            4'd5:    off = OFF_W'(61);
            4'd6:    off = OFF_W'(92);
            4'd7:    off = OFF_W'(122);
            4'd8:    off = OFF_W'(153);
            4'd9:    off = OFF_W'(184);
            4'd10:   off = OFF_W'(214);
            4'd11:   off = OFF_W'(245);
            4'd12:   off = OFF_W'(275);
            4'd1:    off = OFF_W'(306);
            4'd2:    off = OFF_W'(337);
            default: off = OFF_W'(0);
        endcase
        return off;
    endfunction

endpackage

// File: rtl/core/gdsd_year_div.sv
`timescale 1ns / 1ps

module gdsd_year_div import gdsd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [DAY_W-1:0]     i_d1,
    input  logic [MONTH_W-1:0]   i_m1,
    input  logic [YEAR_W-1:0]    i_y1,
    input  logic [DAY_W-1:0]     i_d2,
    input  logic [MONTH_W-1:0]   i_m2,
    input  logic [YEAR_W-1:0]    i_y2,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_s1                  o_data
);

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    always_comb begin
        n_data.d1  = i_d1;
        n_data.m1  = i_m1;
        n_data.y1  = i_y1;
        n_data.d2  = i_d2;
        n_data.m2  = i_m2;
        n_data.y2  = i_y2;
        // January and February count towards the previous March-based year.
        n_data.ya1 = (i_m1 <= C_FEB) ? i_y1 - YEAR_W'(1) : i_y1;
        n_data.ya2 = (i_m2 <= C_FEB) ? i_y2 - YEAR_W'(1) : i_y2;
        n_data.q1  = f_div100(i_y1);
        n_data.q2  = f_div100(i_y2);
        n_data.qa1 = f_div100(n_data.ya1);
        n_data.qa2 = f_div100(n_data.ya2);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/gdsd_date_eval.sv
`timescale 1ns / 1ps

module gdsd_date_eval import gdsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s2  o_data
);

    logic             r_valid;
    t_s2              r_data;
    t_s2              n_data;
    logic             leap1;
    logic             leap2;
    logic [DAY_W-1:0] len2;

    function automatic logic f_leap(input logic [YEAR_W-1:0] y,
                                    input logic [Q100_W-1:0] q);
        logic [YEAR_W:0] hundreds;
        hundreds = (YEAR_W+1)'(q) * (YEAR_W+1)'(100);
        // Divisible by four, and either not a century or a century divisible by four.
        return (y[1:0] == 2'b00) && (({1'b0, y} != hundreds) || (q[1:0] == 2'b00));
    endfunction

    function automatic logic f_valid(input logic [DAY_W-1:0] d,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [YEAR_W-1:0] y,
                                     input logic [DAY_W-1:0] len);
        return (y >= C_YEAR_MIN) && (y <= C_YEAR_MAX) && (m >= C_JAN) && (m <= C_DEC)
            && (d != '0) && (d <= len);
    endfunction

    function automatic logic [DNUM_W-1:0] f_day_number(input logic [DAY_W-1:0] d,
                                                       input logic [MONTH_W-1:0] m,
                                                       input logic [YEAR_W-1:0] ya,
                                                       input logic [Q100_W-1:0] qa);
        return DNUM_W'(ya) * DNUM_W'(365) + DNUM_W'(ya >> 2) - DNUM_W'(qa)
             + DNUM_W'(qa >> 2) + DNUM_W'(f_month_offset(m)) + DNUM_W'(d) - DNUM_W'(1);
    endfunction

    always_comb begin
        leap1            = f_leap(i_data.y1, i_data.q1);
        leap2            = f_leap(i_data.y2, i_data.q2);
        n_data.len1      = f_month_len(i_data.m1, leap1);
        len2             = f_month_len(i_data.m2, leap2);
        n_data.v1        = f_valid(i_data.d1, i_data.m1, i_data.y1, n_data.len1);
        n_data.v2        = f_valid(i_data.d2, i_data.m2, i_data.y2, len2);
        // Stepping back out of January lands in December, which always has 31 days.
        n_data.prev_len1 = (i_data.m1 == C_JAN) ? f_month_len(C_DEC, 1'b0)
                                                : f_month_len(i_data.m1 - MONTH_W'(1), leap1);
        n_data.d1        = i_data.d1;
        n_data.m1        = i_data.m1;
        n_data.y1        = i_data.y1;
        n_data.n1        = f_day_number(i_data.d1, i_data.m1, i_data.ya1, i_data.qa1);
        n_data.n2        = f_day_number(i_data.d2, i_data.m2, i_data.ya2, i_data.qa2);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/gdsd_result.sv
`timescale 1ns / 1ps

module gdsd_result import gdsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s2  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_data
);

    logic r_valid;
    t_res r_data;
    t_res n_data;

    always_comb begin
        n_data              = '0;
        n_data.first_valid  = i_data.v1;
        n_data.second_valid = i_data.v2;
        if (i_data.v1) begin
            n_data.month_length = i_data.len1;
            n_data.next_day     = i_data.d1 + DAY_W'(1);
            n_data.next_month   = i_data.m1;
            n_data.next_year    = i_data.y1;
            if (i_data.d1 == i_data.len1) begin
                n_data.next_day = DAY_W'(1);
                if (i_data.m1 == C_DEC) begin
                    n_data.next_month = C_JAN;
                    n_data.next_year  = i_data.y1 + YEAR_W'(1);
                end else begin
                    n_data.next_month = i_data.m1 + MONTH_W'(1);
                end
            end
            n_data.prev_day   = i_data.d1 - DAY_W'(1);
            n_data.prev_month = i_data.m1;
            n_data.prev_year  = i_data.y1;
            if (i_data.d1 == DAY_W'(1)) begin
                n_data.prev_day = i_data.prev_len1;
                if (i_data.m1 == C_JAN) begin
                    n_data.prev_month = C_DEC;
                    n_data.prev_year  = i_data.y1 - YEAR_W'(1);
                end else begin
                    n_data.prev_month = i_data.m1 - MONTH_W'(1);
                end
            end
        end
        if (i_data.v1 && i_data.v2) begin
            n_data.day_difference = DIFF_W'(i_data.n2) - DIFF_W'(i_data.n1);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_invalid_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.first_valid) |->
            (r_data.month_length == '0 && r_data.next_year == '0 && r_data.prev_year == '0))
        else $error("invalid first date left non-zero step results");

    a_invalid_diff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !(r_data.first_valid && r_data.second_valid)) |->
            (r_data.day_difference == '0))
        else $error("day difference non-zero with an invalid date");

    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.first_valid) |->
            (r_data.next_day != '0 && r_data.next_month >= C_JAN
             && r_data.next_month <= C_DEC && r_data.next_day <= r_data.month_length + 1))
        else $error("next date out of range");

    a_prev_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.first_valid) |->
            (r_data.prev_day != '0 && r_data.prev_month >= C_JAN
             && r_data.prev_month <= C_DEC))
        else $error("previous date out of range");

endmodule

// File: rtl/core/gregorian_date_step_and_difference.sv
`timescale 1ns / 1ps

// Gregorian date step and difference. Each request carries two dates and
// yields one result: the validity of each date (years 1900 to 30000), the
// length of the first date's month, the day after and the day before the
// first date, and the signed day count from the first date to the second.
// Step results are zero when the first date is invalid, and the difference
// is zero when either date is invalid. The block is a three-stage pipeline
// (hundreds of the year by reciprocal multiply, then validity and day
// numbers, then stepping and subtraction); it takes one request per cycle
// while the result output is not stalled. Each stage holds its item while
// the stage after it is full and stalled, so empty stages still fill while
// a result waits at the output.

module gregorian_date_step_and_difference import gdsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // first_day[4:0], first_month[8:5], first_year[23:9],
    // second_day[28:24], second_month[32:29], second_year[47:33]
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // month_length[4:0], next_day[9:5], next_month[13:10], next_year[28:14],
    // prev_day[33:29], prev_month[37:34], prev_year[52:38],
    // day_difference[77:53], zero[79:78]
    output logic [79:0] o_m_tdata,
    // first_valid[0], second_valid[1]
    output logic [1:0]  o_m_tuser
);

    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;
    t_res res;

    gdsd_year_div u_year_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_d1    (i_s_tdata[4:0]),
        .i_m1    (i_s_tdata[8:5]),
        .i_y1    (i_s_tdata[23:9]),
        .i_d2    (i_s_tdata[28:24]),
        .i_m2    (i_s_tdata[32:29]),
        .i_y2    (i_s_tdata[47:33]),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    gdsd_date_eval u_date_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    gdsd_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (res)
    );

    assign o_m_tuser = {res.second_valid, res.first_valid};
    assign o_m_tdata = {2'b00, res.day_difference, res.prev_year, res.prev_month,
                        res.prev_day, res.next_year, res.next_month, res.next_day,
                        res.month_length};

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gdsd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    // first_day[4:0], first_month[8:5], first_year[23:9],
    // second_day[28:24], second_month[32:29], second_year[47:33]
    logic [47:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    // month_length[4:0], next_day[9:5], next_month[13:10], next_year[28:14],
    // prev_day[33:29], prev_month[37:34], prev_year[52:38],
    // day_difference[77:53], zero[79:78]
    logic [79:0] m_data;
    // first_valid[0], second_valid[1]
    logic [1:0]  m_user;

    logic [47:0] pending_requests[$];
    t_res        expected_dates[$];
    logic [47:0] next_req;
    int          send_gap = 0;
    int          send_calm = 0;
    int          recv_hold = 0;
    int          recv_calm = 0;
    int          mismatch_count = 0;
    int          accepted_count = 0;
    int          checked_count = 0;
    int          valid_pair_count = 0;

    gregorian_date_step_and_difference i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            default:               n = is_leap(y) ? 29 : 28;
        endcase
        return n;
    endfunction

    function automatic bit date_ok(input int unsigned d, input int unsigned m,
                                   input int unsigned y);
        if (y < C_YEAR_MIN || y > C_YEAR_MAX) return 1'b0;
        if (m < 1 || m > 12) return 1'b0;
        return (d >= 1) && (d <= month_days(m, y));
    endfunction

    // Days since a fixed epoch, counting each year from March so that the
    // leap day sits at the end of the counted year.
    function automatic int day_index(input int unsigned d, input int unsigned m,
                                     input int unsigned y);
        int unsigned ya;
        int unsigned doy;
        ya  = (m <= 2) ? y - 1 : y;
        doy = (153 * ((m + 9) % 12) + 2) / 5 + d - 1;
        return 365 * ya + ya / 4 - ya / 100 + ya / 400 + doy;
    endfunction

    function automatic t_res step_and_diff(input logic [47:0] req);
        int unsigned d1, m1, y1, d2, m2, y2, len, pm, py;
        t_res r;
        d1 = req[4:0];
        m1 = req[8:5];
        y1 = req[23:9];
        d2 = req[28:24];
        m2 = req[32:29];
        y2 = req[47:33];
        r = '0;
        r.first_valid  = date_ok(d1, m1, y1);
        r.second_valid = date_ok(d2, m2, y2);
        if (r.first_valid) begin
            len = month_days(m1, y1);
            r.month_length = DAY_W'(len);
            if (d1 == len) begin
                r.next_day   = DAY_W'(1);
                r.next_month = (m1 == 12) ? MONTH_W'(1) : MONTH_W'(m1 + 1);
                r.next_year  = (m1 == 12) ? YEAR_W'(y1 + 1) : YEAR_W'(y1);
            end else begin
                r.next_day   = DAY_W'(d1 + 1);
                r.next_month = MONTH_W'(m1);
                r.next_year  = YEAR_W'(y1);
            end
            if (d1 == 1) begin
                pm = (m1 == 1) ? 12 : m1 - 1;
                py = (m1 == 1) ? y1 - 1 : y1;
                r.prev_day = DAY_W'(month_days(pm, py));
            end else begin
                pm = m1;
                py = y1;
                r.prev_day = DAY_W'(d1 - 1);
            end
            r.prev_month = MONTH_W'(pm);
            r.prev_year  = YEAR_W'(py);
        end
        if (r.first_valid && r.second_valid)
            r.day_difference = DIFF_W'(day_index(d2, m2, y2) - day_index(d1, m1, y1));
        return r;
    endfunction

    function automatic logic [47:0] pack_request(input int unsigned d1, input int unsigned m1,
                                                 input int unsigned y1, input int unsigned d2,
                                                 input int unsigned m2, input int unsigned y2);
        return {YEAR_W'(y2), MONTH_W'(m2), DAY_W'(d2), YEAR_W'(y1), MONTH_W'(m1), DAY_W'(d1)};
    endfunction

    // Mostly back to back, some short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned random_year();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return $urandom_range(1900, 1906);
        if (r < 24) return $urandom_range(29994, 30000);
        if (r < 55) return $urandom_range(1895, 2105);
        return $urandom_range(1900, 30000);
    endfunction

    function automatic int unsigned random_day(input int unsigned m, input int unsigned y);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 1;
        if (r < 4) return month_days(m, y);
        return $urandom_range(1, month_days(m, y));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string field, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (expected_dates.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding, data %h", m_data));
        end else begin
            want = expected_dates.pop_front();
            compare_field("first_valid", got.first_valid, want.first_valid);
            compare_field("second_valid", got.second_valid, want.second_valid);
            compare_field("month_length", got.month_length, want.month_length);
            compare_field("next_day", got.next_day, want.next_day);
            compare_field("next_month", got.next_month, want.next_month);
            compare_field("next_year", got.next_year, want.next_year);
            compare_field("prev_day", got.prev_day, want.prev_day);
            compare_field("prev_month", got.prev_month, want.prev_month);
            compare_field("prev_year", got.prev_year, want.prev_year);
            compare_field("day_difference", got.day_difference, want.day_difference);
            if (want.first_valid && want.second_valid) valid_pair_count++;
        end
        checked_count++;
    endtask

    // Request driver: the expectation is queued as the request goes onto the
    // bus, which keeps it ahead of its result whatever the pipeline does.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) accepted_count <= accepted_count + 1;
            if (send_gap != 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_requests.size() != 0) begin
                next_req = pending_requests.pop_front();
                s_data   <= next_req;
                s_valid  <= 1'b1;
                expected_dates.push_back(step_and_diff(next_req));
                send_gap <= (send_calm != 0) ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
            if (send_calm != 0) send_calm <= send_calm - 1;
            else if ($urandom_range(0, 39) == 0) send_calm <= $urandom_range(20, 80);
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_valid && m_ready)
                check_result({m_user[0], m_user[1], m_data[4:0], m_data[9:5], m_data[13:10],
                              m_data[28:14], m_data[33:29], m_data[37:34], m_data[52:38],
                              m_data[77:53]});
            if (recv_hold != 0) begin
                m_ready   <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else begin
                m_ready   <= 1'b1;
                recv_hold <= (recv_calm != 0) ? 0 : pick_gap();
            end
            if (recv_calm != 0) recv_calm <= recv_calm - 1;
            else if ($urandom_range(0, 39) == 0) recv_calm <= $urandom_range(20, 80);
        end
    end

    initial begin
        int unsigned d1, m1, y1, d2, m2, y2;
        int          kind;
        int          guard;

        // Field extremes and invalid encodings.
        pending_requests.push_back(pack_request(0, 0, 0, 0, 0, 0));
        pending_requests.push_back(pack_request(31, 15, 32767, 31, 15, 32767));
        pending_requests.push_back(pack_request(1, 13, 2000, 1, 1, 2000));
        pending_requests.push_back(pack_request(0, 5, 2000, 15, 5, 2000));
        pending_requests.push_back(pack_request(31, 4, 2001, 1, 4, 2001));
        pending_requests.push_back(pack_request(15, 6, 1899, 15, 6, 1900));
        pending_requests.push_back(pack_request(15, 6, 30001, 15, 6, 30000));
        pending_requests.push_back(pack_request(10, 3, 2020, 10, 3, 30001));
        pending_requests.push_back(pack_request(10, 3, 2020, 0, 3, 2020));
        // Leap rule: divisible by 400, by 100 only, by 4 only, and not at all.
        pending_requests.push_back(pack_request(29, 2, 2000, 1, 3, 2000));
        pending_requests.push_back(pack_request(29, 2, 1900, 1, 3, 1900));
        pending_requests.push_back(pack_request(28, 2, 1900, 1, 3, 1900));
        pending_requests.push_back(pack_request(29, 2, 2004, 28, 2, 2005));
        pending_requests.push_back(pack_request(28, 2, 2003, 29, 2, 2003));
        pending_requests.push_back(pack_request(1, 3, 2400, 1, 3, 2100));
        // Rollover across month and year, including past both ends of the range.
        pending_requests.push_back(pack_request(31, 12, 30000, 1, 1, 1900));
        pending_requests.push_back(pack_request(1, 1, 1900, 31, 12, 30000));
        pending_requests.push_back(pack_request(31, 12, 1999, 1, 1, 2000));
        pending_requests.push_back(pack_request(1, 1, 2000, 31, 12, 1999));
        pending_requests.push_back(pack_request(30, 4, 2010, 1, 5, 2010));
        pending_requests.push_back(pack_request(1, 5, 2010, 30, 4, 2010));
        // Same year, different month, in both directions, then two identical dates.
        pending_requests.push_back(pack_request(15, 1, 2023, 20, 11, 2023));
        pending_requests.push_back(pack_request(20, 11, 2023, 15, 1, 2023));
        pending_requests.push_back(pack_request(7, 7, 2023, 7, 7, 2023));

        for (int n = 0; n < 900; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                pending_requests.push_back(48'({$urandom(), $urandom()}));
            end else begin
                y1 = random_year();
                m1 = $urandom_range(1, 12);
                d1 = random_day(m1, y1);
                y2 = ($urandom_range(0, 2) == 0) ? y1 : random_year();
                m2 = $urandom_range(1, 12);
                d2 = random_day(m2, y2);
                if (kind < 22) d1 = $urandom_range(0, 1) ? 0 : month_days(m1, y1) + 1;
                else if (kind < 27) d2 = $urandom_range(0, 1) ? 0 : $urandom_range(29, 31);
                else if (kind < 31) m1 = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
                pending_requests.push_back(pack_request(d1, m1, y1, d2, m2, y2));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) @(posedge i_clk);
        guard = 0;
        while (expected_dates.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_dates.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));

        $display("Sent %0d date-pair requests and checked %0d results, %0d with both dates valid.",
                 accepted_count, checked_count, valid_pair_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out waiting for the block.");
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: gregorian_date_step_and_difference.f
rtl/core/gdsd_pkg.sv
rtl/core/gdsd_year_div.sv
rtl/core/gdsd_date_eval.sv
rtl/core/gdsd_result.sv
rtl/core/gregorian_date_step_and_difference.sv
test/tb_top.sv
